// ----- src/rle_enc_pkg.sv -----
// Shared constants for the multi-byte symbol run-length encoder.
package rle_enc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned LEN_W   = 4;

    // longest run one record may carry
    localparam logic [COUNT_W-1:0] RUN_LIMIT = 8'd255;

    // register map (index = byte address / 4)
    typedef enum logic {
        REG_PATTERN_LENGTH = 1'b0,
        REG_UNUSED         = 1'b1
    } t_cfg_reg;

    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 4'd1;

    // push side of the result queue
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push_ctl;

endpackage

// ----- src/rle_enc_outq.sv -----
// Four-entry result queue taking up to two records per cycle.
module rle_enc_outq
    import rle_enc_pkg::*;
#(
    parameter int DATA_W = 73
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push_ctl         i_push,
    input  logic [DATA_W-1:0] i_data0,
    input  logic [DATA_W-1:0] i_data1,
    output logic              o_room2,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;
    logic [CNT_W-1:0]  n_push;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    // room for two records, ignoring a pop in the same cycle
    assign o_room2 = (r_count <= CNT_W'(DEPTH - 2));

    always_comb begin
        n_push  = CNT_W'(i_push.push0) + CNT_W'(i_push.push1);
        n_wptr  = r_wptr + PTR_W'(n_push);
        n_rptr  = r_rptr + PTR_W'(pop);
        n_count = r_count + n_push - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wptr] <= i_data0;
        end
        if (i_push.push1) begin
            r_mem[r_wptr + PTR_W'(1)] <= i_data1;
        end
    end

endmodule

// ----- src/rle_pattern_encoder_top.sv -----
// Top level of the multi-byte symbol run-length encoder.
// A record is registered into the result queue when the byte that closes it is accepted.
// Throughput: one byte per cycle while o_ready is high; compare, count update and queue push act on the accepted byte.
// A byte may emit two records (run close plus end of stream); the 4-entry result
// queue absorbs them, and o_ready drops only while more than two records wait.
// Reset (synchronous, active low): no symbol held, run and fill cleared, group bytes
// zeroed, pattern_length = 1, result queue empty. No clearing pass.
module rle_pattern_encoder_top
    import rle_enc_pkg::*;
#(
    parameter int P_MAX_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // byte stream in
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [BYTE_W-1:0]          i_in_byte,
    input  logic                       i_end_of_stream,
    // records out
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [COUNT_W-1:0]         o_run_count,
    output logic [BYTE_W*P_MAX_BYTES-1:0] o_run_pattern,
    output logic                       o_final_run,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int PAT_W = BYTE_W * P_MAX_BYTES;
    localparam int IDX_W = (P_MAX_BYTES > 1) ? $clog2(P_MAX_BYTES) : 1;
    localparam int REC_W = COUNT_W + PAT_W + 1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] r_pattern_length;
    logic             cfg_wr;
    t_cfg_reg         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = t_cfg_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= PATTERN_LENGTH_RESET;
        end else if (cfg_wr && (cfg_sel == REG_PATTERN_LENGTH)) begin
            r_pattern_length <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_PATTERN_LENGTH: prdata = {{(32-LEN_W){1'b0}}, r_pattern_length};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Encoder state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]  r_group [P_MAX_BYTES];   // bytes of the group being filled
    logic [BYTE_W-1:0]  r_held  [P_MAX_BYTES];   // symbol of the open run, no reset
    logic [IDX_W-1:0]   r_fill;
    logic [COUNT_W-1:0] r_run;
    logic               r_have;

    logic [BYTE_W-1:0]  n_group [P_MAX_BYTES];
    logic [BYTE_W-1:0]  sym     [P_MAX_BYTES];
    logic [IDX_W-1:0]   n_fill;
    logic [COUNT_W-1:0] n_run;
    logic               n_have;
    logic               load_held;

    logic               accept;
    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   next_pos;
    logic               complete;
    logic               match;
    logic               restart;
    logic [COUNT_W-1:0] run_after;
    logic [PAT_W-1:0]   held_flat;
    logic [PAT_W-1:0]   held_after;
    logic [PAT_W-1:0]   sym_flat;

    t_push_ctl          push;
    logic [REC_W-1:0]   rec_close;
    logic [REC_W-1:0]   rec_final;
    logic [REC_W-1:0]   q_data0;
    logic               q_room2;
    logic [REC_W-1:0]   q_out;

    assign o_ready = q_room2;
    assign accept  = i_valid && o_ready;

    // length 0 acts as 1, anything past the maximum acts as the maximum
    always_comb begin
        if (r_pattern_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_pattern_length > LEN_W'(P_MAX_BYTES)) begin
            eff_len = LEN_W'(P_MAX_BYTES);
        end else begin
            eff_len = r_pattern_length;
        end
    end

    assign next_pos = LEN_W'(r_fill) + LEN_W'(1);
    assign complete = (next_pos >= eff_len) || i_end_of_stream;

    // drop the byte into the group, mask the symbol, compare with the held one
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < P_MAX_BYTES; i++) begin
            n_group[i] = (IDX_W'(i) == r_fill) ? i_in_byte : r_group[i];
            sym[i]     = (LEN_W'(i) < eff_len) ? n_group[i] : '0;
            if ((LEN_W'(i) < eff_len) && (n_group[i] != r_held[i])) begin
                match = 1'b0;
            end
            held_flat[i*BYTE_W +: BYTE_W] = r_held[i];
            sym_flat[i*BYTE_W +: BYTE_W]  = sym[i];
        end
    end

    // Closing record: symbol changed, or the run is full and repeats again.
    // In both cases the record carries the current count and held symbol.
    always_comb begin
        load_held  = complete && (!r_have || !match);
        restart    = load_held || (r_run >= RUN_LIMIT);
        run_after  = restart ? COUNT_W'(1) : r_run + COUNT_W'(1);
        held_after = load_held ? sym_flat : held_flat;

        push.push0 = 1'b0;
        push.push1 = 1'b0;
        if (accept) begin
            if (complete && r_have && (!match || (r_run >= RUN_LIMIT))) begin
                push.push0 = 1'b1;
                push.push1 = i_end_of_stream;
            end else begin
                push.push0 = i_end_of_stream;
            end
        end

        rec_close = {r_run, held_flat, 1'b0};
        rec_final = {run_after, held_after, 1'b1};
        q_data0   = (complete && r_have && (!match || (r_run >= RUN_LIMIT)))
                    ? rec_close : rec_final;

        // next state
        n_fill = r_fill;
        n_run  = r_run;
        n_have = r_have;
        if (accept) begin
            if (complete) begin
                n_fill = '0;
                n_run  = run_after;
                n_have = 1'b1;
            end else begin
                n_fill = r_fill + IDX_W'(1);
            end
            // end of stream: run delivered, next byte opens a new stream
            if (i_end_of_stream) begin
                n_fill = '0;
                n_run  = '0;
                n_have = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_run  <= '0;
            r_have <= 1'b0;
            for (int i = 0; i < P_MAX_BYTES; i++) begin
                r_group[i] <= '0;
            end
        end else begin
            r_fill <= n_fill;
            r_run  <= n_run;
            r_have <= n_have;
            if (accept) begin
                for (int i = 0; i < P_MAX_BYTES; i++) begin
                    r_group[i] <= n_group[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && load_held) begin
            for (int i = 0; i < P_MAX_BYTES; i++) begin
                r_held[i] <= sym[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    rle_enc_outq #(
        .DATA_W (REC_W)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (q_data0),
        .i_data1 (rec_final),
        .o_room2 (q_room2),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (q_out)
    );

    assign o_run_count   = q_out[REC_W-1 -: COUNT_W];
    assign o_run_pattern = q_out[PAT_W:1];
    assign o_final_run   = q_out[0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every end-of-stream transaction yields at least one record
    a_eos_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_stream) |-> push.push0)
        else $error("end of stream produced no record");

    // end of stream leaves the encoder with no open run
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_stream) |=> (!r_have && r_run == '0 && r_fill == '0))
        else $error("state not cleared after end of stream");

    // an open run always counts at least one symbol
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_run != '0))
        else $error("open run with zero count");

    // a second record only accompanies a first one
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push1 |-> (push.push0 && i_end_of_stream))
        else $error("second record without close and end of stream");

endmodule
